// ----- design/mnpt_pkg.sv -----
// Shared types and constants for the mono note priority trigger.
`default_nettype none
package mnpt_pkg;

	localparam int NUM_KEYS_DEF = 32;
	localparam int MASK_W       = 32;
	localparam int STAMP_W      = 32;
	localparam int SEL_W        = 6;
	localparam int MODE_W       = 2;

	// trigger modes; any other code behaves as LFO retrigger
	localparam logic [MODE_W-1:0] MODE_GATE_RETRIG = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SUSTAIN     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LFO         = 2'd2;

	localparam logic signed [SEL_W-1:0] SEL_NONE = -6'sd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_TAIL,
		ST_DONE
	} state_t;

	// stamp RAM update for one key
	typedef struct packed {
		logic               set;
		logic               clr;
		logic [STAMP_W-1:0] data;
	} stamp_op_t;

endpackage
`default_nettype wire

// ----- design/mnpt_in_if.sv -----
// Scan word channel: key masks and LFO edge flag.
`default_nettype none
interface mnpt_in_if;
	logic                        valid;
	logic                        ready;
	logic [mnpt_pkg::MASK_W-1:0] held_keys;
	logic [mnpt_pkg::MASK_W-1:0] pressed_keys;
	logic [mnpt_pkg::MASK_W-1:0] released_keys;
	logic                        lfo_edge;

	modport source (output valid, held_keys, pressed_keys, released_keys, lfo_edge,
		input ready);
	modport sink (input valid, held_keys, pressed_keys, released_keys, lfo_edge,
		output ready);
endinterface
`default_nettype wire

// ----- design/mnpt_out_if.sv -----
// Result word channel: selected key and envelope controls.
`default_nettype none
interface mnpt_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [mnpt_pkg::SEL_W-1:0] selected_key;
	logic                              gate_on;
	logic                              retrigger;
	logic                              legato;
	logic                              last_note_priority;

	modport source (output valid, selected_key, gate_on, retrigger, legato,
		last_note_priority, input ready);
	modport sink (input valid, selected_key, gate_on, retrigger, legato,
		last_note_priority, output ready);
endinterface
`default_nettype wire

// ----- design/mono_note_priority_trigger.sv -----
// Top level: scan sequencer, mode resolution and result register.
// Each scan word passes through the states idle, scan, tail and done: idle accepts it, scan
// steps the stamp RAM read port through the keys in ascending order with the shared stamp
// comparator one key behind, tail finishes the last key, and done resolves and loads the
// result register. A result that is not taken holds the block in its resolve state.
// Reset leaves every stamp at zero through per-key valid bits; no clearing pass is needed.
// The user must write trigger_mode through cfg_we/cfg_wdata only while the block is idle;
// it does not check this. Code 3 is LFO retrigger; mask bits at or above NUM_KEYS are ignored.
`default_nettype none
module mono_note_priority_trigger #(
	parameter int NUM_KEYS = mnpt_pkg::NUM_KEYS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [mnpt_pkg::MODE_W-1:0] cfg_wdata,
	mnpt_in_if.sink                          scan,
	mnpt_out_if.source                       result
);
	import mnpt_pkg::*;

	localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);

	state_t state_q, state_d;

	logic [MODE_W-1:0]   mode_q;
	logic [NUM_KEYS-1:0] held_q, pressed_q, released_q;
	logic                lfo_q;
	logic                prev_held_q;
	logic [KW-1:0]       k_q, k_s1;
	logic                step_s1;

	logic                accept, load;
	logic [STAMP_W-1:0]  rd_stamp;
	stamp_op_t           op;
	logic                best_found, lp_found, lh_found;
	logic [KW-1:0]       best_key, lp_key, lh_key;

	logic                any_held, any_pressed, legato_d, retrig_d;
	logic signed [SEL_W-1:0] sel_d;

	logic                    out_valid_q;
	logic signed [SEL_W-1:0] sel_q;
	logic                    gate_q, retrig_q, legato_q, lnp_q;

	assign accept = scan.valid && scan.ready;

	always_comb begin
		state_d    = state_q;
		scan.ready = 1'b0;
		load       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				scan.ready = 1'b1;
				if (scan.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (k_q == LAST_KEY) begin
					state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_GATE_RETRIG;
			prev_held_q <= 1'b0;
			step_s1     <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			step_s1 <= (state_q == ST_SCAN);
			if (accept) begin
				k_q <= '0;
			end else if (state_q == ST_SCAN && k_q != LAST_KEY) begin
				k_q <= k_q + KW'(1);
			end
			if (load) begin
				prev_held_q <= any_held;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q     <= scan.held_keys[NUM_KEYS-1:0];
			pressed_q  <= scan.pressed_keys[NUM_KEYS-1:0];
			released_q <= scan.released_keys[NUM_KEYS-1:0];
			lfo_q      <= scan.lfo_edge;
		end
		k_s1 <= k_q;
	end

	mnpt_stamp_ram #(
		.NUM_KEYS (NUM_KEYS),
		.KW       (KW)
	) u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (k_q),
		.wr_addr  (k_s1),
		.op       (op),
		.rd_stamp (rd_stamp)
	);

	mnpt_scan_unit #(
		.KW (KW)
	) u_scan (
		.clk             (clk),
		.arst_n          (arst_n),
		.clear           (accept),
		.step            (step_s1),
		.key             (k_s1),
		.held            (held_q[k_s1]),
		.pressed         (pressed_q[k_s1]),
		.released        (released_q[k_s1]),
		.rd_stamp        (rd_stamp),
		.op              (op),
		.best_found      (best_found),
		.best_key        (best_key),
		.low_press_found (lp_found),
		.low_press_key   (lp_key),
		.low_held_found  (lh_found),
		.low_held_key    (lh_key)
	);

	// resolve the scan
	always_comb begin
		any_held    = |held_q;
		any_pressed = |pressed_q;
		legato_d    = any_held && any_pressed && (|(held_q & ~pressed_q));
		case (mode_q)
			MODE_GATE_RETRIG: begin
				if (any_pressed) begin
					sel_d = lp_found ? SEL_W'(lp_key) : SEL_NONE;
				end else begin
					sel_d = best_found ? SEL_W'(best_key) : SEL_NONE;
				end
				retrig_d = any_held && any_pressed;
			end
			MODE_SUSTAIN: begin
				sel_d    = lh_found ? SEL_W'(lh_key) : SEL_NONE;
				retrig_d = any_held && !prev_held_q;
			end
			default: begin
				sel_d    = lh_found ? SEL_W'(lh_key) : SEL_NONE;
				retrig_d = any_held && lfo_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sel_q    <= sel_d;
			gate_q   <= any_held;
			retrig_q <= retrig_d;
			legato_q <= legato_d;
			lnp_q    <= (mode_q == MODE_GATE_RETRIG);
		end
	end

	assign result.valid              = out_valid_q;
	assign result.selected_key       = sel_q;
	assign result.gate_on            = gate_q;
	assign result.retrigger          = retrig_q;
	assign result.legato             = legato_q;
	assign result.last_note_priority = lnp_q;

	a_scan_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_SCAN && k_q == '0)
		else $error("scan did not start at key zero");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q == ST_DONE))
		else $error("result appeared outside resolve cycle");

	a_step_tracks_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TAIL |-> step_s1 && k_s1 == LAST_KEY)
		else $error("last key not in stage one at tail");

	a_no_gate_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.last_note_priority && !result.gate_on
		|-> result.selected_key == SEL_NONE)
		else $error("lowest-note mode selected a key with none held");

endmodule
`default_nettype wire

// ----- design/mnpt_stamp_ram.sv -----
// Per-key press stamp RAM with valid bits; invalid entries read as zero.
`default_nettype none
module mnpt_stamp_ram #(
	parameter int NUM_KEYS = mnpt_pkg::NUM_KEYS_DEF,
	parameter int KW       = 5
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [KW-1:0]                rd_addr,
	input  wire logic [KW-1:0]                wr_addr,
	input  wire mnpt_pkg::stamp_op_t          op,
	output logic [mnpt_pkg::STAMP_W-1:0]      rd_stamp
);
	import mnpt_pkg::*;

	logic [STAMP_W-1:0] mem [NUM_KEYS];
	logic [NUM_KEYS-1:0] vld_q;
	logic [STAMP_W-1:0] rd_data_q;
	logic               rd_vld_q;

	always_ff @(posedge clk) begin
		if (op.set) begin
			mem[wr_addr] <= op.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (op.clr) begin
				vld_q[wr_addr] <= 1'b0;
			end else if (op.set) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_stamp = rd_vld_q ? rd_data_q : '0;

endmodule
`default_nettype wire

// ----- design/mnpt_scan_unit.sv -----
// One-key-per-cycle stamp update, newest-stamp compare and lowest-key search.
`default_nettype none
module mnpt_scan_unit #(
	parameter int KW = 5
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         clear,
	input  wire logic                         step,
	input  wire logic [KW-1:0]                key,
	input  wire logic                         held,
	input  wire logic                         pressed,
	input  wire logic                         released,
	input  wire logic [mnpt_pkg::STAMP_W-1:0] rd_stamp,
	output mnpt_pkg::stamp_op_t               op,
	output logic                              best_found,
	output logic [KW-1:0]                     best_key,
	output logic                              low_press_found,
	output logic [KW-1:0]                     low_press_key,
	output logic                              low_held_found,
	output logic [KW-1:0]                     low_held_key
);
	import mnpt_pkg::*;

	logic [STAMP_W-1:0] cnt_q;
	logic [STAMP_W-1:0] cnt_inc;
	logic [STAMP_W-1:0] new_stamp;
	logic [STAMP_W-1:0] best_stamp_q;
	logic               best_found_q, lp_found_q, lh_found_q;
	logic [KW-1:0]      best_key_q, lp_key_q, lh_key_q;
	logic               newer;

	assign cnt_inc = cnt_q + 32'd1;

	always_comb begin
		if (released) begin
			new_stamp = '0;
		end else if (pressed) begin
			new_stamp = cnt_inc;
		end else begin
			new_stamp = rd_stamp;
		end
		newer = held && (!best_found_q || (new_stamp > best_stamp_q));
		op.set  = step && pressed && !released;
		op.clr  = step && released;
		op.data = cnt_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			best_found_q <= 1'b0;
			lp_found_q   <= 1'b0;
			lh_found_q   <= 1'b0;
		end else if (clear) begin
			best_found_q <= 1'b0;
			lp_found_q   <= 1'b0;
			lh_found_q   <= 1'b0;
		end else if (step) begin
			if (pressed) begin
				cnt_q <= cnt_inc;
			end
			if (newer) begin
				best_found_q <= 1'b1;
			end
			if (pressed) begin
				lp_found_q <= 1'b1;
			end
			if (held) begin
				lh_found_q <= 1'b1;
			end
		end
	end

	// payload side: keys and stamp follow the found flags
	always_ff @(posedge clk) begin
		if (step && !clear) begin
			if (newer) begin
				best_key_q   <= key;
				best_stamp_q <= new_stamp;
			end
			if (pressed && !lp_found_q) begin
				lp_key_q <= key;
			end
			if (held && !lh_found_q) begin
				lh_key_q <= key;
			end
		end
	end

	assign best_found      = best_found_q;
	assign best_key        = best_key_q;
	assign low_press_found = lp_found_q;
	assign low_press_key   = lp_key_q;
	assign low_held_found  = lh_found_q;
	assign low_held_key    = lh_key_q;

endmodule
`default_nettype wire

// ----- bench/mnpt_trigger_checker.sv -----
`timescale 1ns / 100ps
// Checker: follows the scan and result channels, predicts each result word and compares.
module mnpt_trigger_checker
	import mnpt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [MODE_W-1:0] cfg_wdata,
	mnpt_in_if                     scan,
	mnpt_out_if                    result,
	output int                     outstanding,
	output int                     fail_count
);

	typedef struct packed {
		logic signed [SEL_W-1:0] key;
		logic                    gate;
		logic                    retrig;
		logic                    legato;
		logic                    last_prio;
	} trig_t;

	logic [STAMP_W-1:0] key_stamp [MASK_W];
	logic [STAMP_W-1:0] press_total;
	logic               any_held_q;
	logic [MODE_W-1:0]  mode;
	trig_t              trig_q [$];
	int                 err_count;

	function automatic logic signed [SEL_W-1:0] lowest_key(input logic [MASK_W-1:0] bits);
		logic signed [SEL_W-1:0] sel;
		sel = SEL_NONE;
		for (int k = MASK_W - 1; k >= 0; k--) begin
			if (bits[k])
				sel = SEL_W'(k);
		end
		return sel;
	endfunction

	// newest stamp wins; strict compare keeps the lower key on a tie
	function automatic logic signed [SEL_W-1:0] newest_key(input logic [MASK_W-1:0] held);
		logic signed [SEL_W-1:0] sel;
		logic [STAMP_W-1:0]      top_stamp;
		sel = SEL_NONE;
		top_stamp = '0;
		for (int k = 0; k < MASK_W; k++) begin
			if (held[k] && (sel == SEL_NONE || key_stamp[k] > top_stamp)) begin
				sel = SEL_W'(k);
				top_stamp = key_stamp[k];
			end
		end
		return sel;
	endfunction

	function automatic trig_t resolve_scan(input logic [MASK_W-1:0] held,
		input logic [MASK_W-1:0] pressed, input logic [MASK_W-1:0] released,
		input logic lfo);
		trig_t r;
		logic  onset;
		logic  any_held;
		logic  any_pressed;
		for (int k = 0; k < MASK_W; k++) begin
			if (pressed[k]) begin
				press_total = press_total + STAMP_W'(1);
				key_stamp[k] = press_total;
			end
		end
		for (int k = 0; k < MASK_W; k++) begin
			if (released[k])
				key_stamp[k] = '0;
		end
		any_held = held != '0;
		any_pressed = pressed != '0;
		onset = any_held && !any_held_q;
		any_held_q = any_held;
		r.gate = any_held;
		r.legato = any_held && ((held & ~pressed) != '0) && any_pressed;
		r.last_prio = mode == MODE_GATE_RETRIG;
		if (mode == MODE_GATE_RETRIG) begin
			r.key = any_pressed ? lowest_key(pressed) : newest_key(held);
			r.retrig = any_held && any_pressed;
		end else if (mode == MODE_SUSTAIN) begin
			r.key = lowest_key(held);
			r.retrig = onset;
		end else begin
			r.key = lowest_key(held);
			r.retrig = any_held && lfo;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		trig_t want;
		trig_t got;
		if (!arst_n) begin
			for (int k = 0; k < MASK_W; k++)
				key_stamp[k] = '0;
			press_total = '0;
			any_held_q = 1'b0;
			mode = MODE_GATE_RETRIG;
			trig_q.delete();
			err_count = 0;
		end else begin
			if (cfg_we)
				mode = cfg_wdata;
			if (scan.valid && scan.ready)
				trig_q.push_back(resolve_scan(scan.held_keys, scan.pressed_keys,
					scan.released_keys, scan.lfo_edge));
			if (result.valid && result.ready) begin
				got.key = result.selected_key;
				got.gate = result.gate_on;
				got.retrig = result.retrigger;
				got.legato = result.legato;
				got.last_prio = result.last_note_priority;
				if (trig_q.size() == 0) begin
					err_count++;
					$display("%0t: result word with none expected:", $time,
						" key=%0d gate=%b retrig=%b legato=%b lnp=%b",
						got.key, got.gate, got.retrig, got.legato, got.last_prio);
				end else begin
					want = trig_q.pop_front();
					if (got !== want) begin
						err_count++;
						$display("%0t: mismatch expected", $time,
							" key=%0d gate=%b retrig=%b legato=%b lnp=%b",
							want.key, want.gate, want.retrig, want.legato,
							want.last_prio);
						$display("%0t:          actual  ", $time,
							" key=%0d gate=%b retrig=%b legato=%b lnp=%b",
							got.key, got.gate, got.retrig, got.legato,
							got.last_prio);
					end
				end
			end
		end
		outstanding <= trig_q.size();
		fail_count <= err_count;
	end

endmodule

// ----- bench/mono_note_priority_trigger_tb.sv -----
`timescale 1ns / 100ps
// Testbench top: clock, reset, scan word stimulus, result back-pressure and verdict.
module mono_note_priority_trigger_tb;
	import mnpt_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int TAIL_CYCLES = 40;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 90;
	localparam logic [MODE_W-1:0] PHASE_MODE [PHASES] = '{MODE_SUSTAIN, MODE_UNUSED,
		MODE_GATE_RETRIG, MODE_LFO, MODE_UNUSED, MODE_SUSTAIN, MODE_GATE_RETRIG, MODE_LFO};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [MODE_W-1:0] cfg_wdata;
	int                outstanding;
	int                fail_count;
	bit                steady = 1'b0;
	logic [MASK_W-1:0] keys_down;

	mnpt_in_if  scan_bus ();
	mnpt_out_if result_bus ();

	mono_note_priority_trigger u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.scan      (scan_bus),
		.result    (result_bus)
	);

	mnpt_trigger_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.scan        (scan_bus),
		.result      (result_bus),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [MASK_W-1:0] few_keys(input logic [MASK_W-1:0] allowed, input int n);
		logic [MASK_W-1:0] bits;
		int                k;
		bits = '0;
		repeat (n) begin
			k = $urandom_range(0, MASK_W - 1);
			if (allowed[k])
				bits[k] = 1'b1;
		end
		return bits;
	endfunction

	task automatic send_scan(input logic [MASK_W-1:0] held, input logic [MASK_W-1:0] pressed,
		input logic [MASK_W-1:0] released, input logic lfo);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			scan_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		scan_bus.valid <= 1'b1;
		scan_bus.held_keys <= held;
		scan_bus.pressed_keys <= pressed;
		scan_bus.released_keys <= released;
		scan_bus.lfo_edge <= lfo;
		@(posedge clk);
		while (!scan_bus.ready)
			@(posedge clk);
	endtask

	// register writes only once the block has drained
	task automatic set_mode(input logic [MODE_W-1:0] m);
		scan_bus.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly plausible key traffic, some raw noise
	task automatic random_scan();
		logic [MASK_W-1:0] held;
		logic [MASK_W-1:0] pressed;
		logic [MASK_W-1:0] released;
		int                r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			held = $urandom;
			pressed = $urandom;
			released = $urandom;
		end else if (r < 20) begin
			held = '0;
			pressed = '0;
			released = keys_down;
		end else begin
			pressed = few_keys(~keys_down, ($urandom_range(0, 9) == 0) ? 6 : $urandom_range(0, 2));
			released = few_keys(keys_down, $urandom_range(0, 2));
			held = (keys_down & ~released) | pressed;
		end
		keys_down = held;
		send_scan(held, pressed, released, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= MODE_GATE_RETRIG;
		scan_bus.valid <= 1'b0;
		scan_bus.held_keys <= '0;
		scan_bus.pressed_keys <= '0;
		scan_bus.released_keys <= '0;
		scan_bus.lfo_edge <= 1'b0;
		keys_down = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_mode(MODE_GATE_RETRIG);
		send_scan('0, '0, '0, 1'b0);
		send_scan(32'h0000_0001, 32'h0000_0001, '0, 1'b0);
		send_scan(32'h8000_0001, 32'h8000_0000, '0, 1'b1);
		send_scan(32'h8000_0000, '0, 32'h0000_0001, 1'b0);
		send_scan(32'h8000_0000, '0, '0, 1'b0);
		send_scan('1, '1, '0, 1'b1);
		send_scan('1, '0, '0, 1'b0);
		send_scan('0, '0, '1, 1'b0);
		// held keys that carry no stamp: tie goes to the lowest
		send_scan(32'h0000_f000, '0, '0, 1'b0);
		// press and release of one key in the same scan
		send_scan('0, 32'h0000_0020, 32'h0000_0020, 1'b0);
		// new press outside the held mask
		send_scan(32'h0000_0008, 32'h0000_0080, '0, 1'b0);
		send_scan(32'h0000_0088, '0, '0, 1'b1);
		send_scan('0, '0, '1, 1'b1);

		set_mode(MODE_SUSTAIN);
		send_scan('0, '0, '0, 1'b0);
		send_scan(32'h0000_0010, 32'h0000_0010, '0, 1'b0);
		send_scan(32'h0000_0030, 32'h0000_0020, '0, 1'b1);
		send_scan('0, '0, 32'h0000_0030, 1'b0);

		set_mode(MODE_UNUSED);
		send_scan(32'h4000_0000, 32'h4000_0000, '0, 1'b1);
		send_scan(32'h4000_0000, '0, '0, 1'b0);
		send_scan('0, '0, 32'h4000_0000, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			set_mode(PHASE_MODE[p]);
			steady = (p == 4);
			repeat (PHASE_ITEMS) random_scan();
		end
		steady = 1'b0;

		scan_bus.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// result side: random stalls, plus two long hold-offs that back up the scan input
	initial begin
		int rounds;
		int stall;
		result_bus.ready <= 1'b0;
		rounds = 0;
		@(posedge clk);
		forever begin
			if (rounds == 30 || rounds == 2000)
				stall = 500;
			else if (steady)
				stall = 0;
			else
				stall = pick_gap();
			if (stall > 0) begin
				result_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			rounds++;
		end
	end

endmodule

// ----- filelist.f -----
design/mnpt_pkg.sv
design/mnpt_in_if.sv
design/mnpt_out_if.sv
design/mnpt_stamp_ram.sv
design/mnpt_scan_unit.sv
design/mono_note_priority_trigger.sv
bench/mnpt_trigger_checker.sv
bench/mono_note_priority_trigger_tb.sv
